FILE: src/held_key_table_with_timers_defines.svh
// Assertion macros for the held key table.
`ifndef HELD_KEY_TABLE_WITH_TIMERS_DEFINES_SVH
`define HELD_KEY_TABLE_WITH_TIMERS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define HKT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HKT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/hkt_pkg.sv
// Shared types and constants of the held key table.
package hkt_pkg;

   localparam int SLOTS   = 16;
   localparam int KEY_W   = 32;
   localparam int TIME_W  = 16;
   localparam int IDX_W   = ($clog2(SLOTS) > 4) ? $clog2(SLOTS) : 4;
   localparam int CNT_W   = ($clog2(SLOTS + 1) > 5) ? $clog2(SLOTS + 1) : 5;

   localparam logic [TIME_W-1:0] RELOAD_RESET = 16'd4096;

   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic [2:0] STATUS_REFRESHED = 3'd0;
   localparam logic [2:0] STATUS_INSERTED  = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_RELEASED  = 3'd3;
   localparam logic [2:0] STATUS_TICKED    = 3'd4;
   localparam logic [2:0] STATUS_IGNORED   = 3'd5;

   localparam logic [4:0] CLEARED_MAX = 5'd31;

   typedef struct packed {
      logic [1:0]        operation;
      logic [KEY_W-1:0]  key_code;
      logic [TIME_W-1:0] elapsed_time;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot_index;
      logic [4:0] cleared_count;
   } rsp_type;

   // Beat that walks down the cell row, one cell per cycle.
   typedef struct packed {
      logic              valid;
      logic [1:0]        op;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] dt;
      logic              match_found;
      logic [IDX_W-1:0]  match_idx;
      logic              free_found;
      logic [IDX_W-1:0]  free_idx;
      logic [CNT_W-1:0]  count;
   } wave_type;

   // Broadcast write of a new key into one cell.
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
   } commit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } ctrl_state_type;

endpackage

FILE: src/held_key_table_with_timers.sv
// Top level of the held key table with per-slot countdown timers.
// Usage:
//  - req_* takes one beat per event: key press, key release or time tick
//    (req_data.operation), with key_code and elapsed_time. rsp_* returns
//    exactly one beat per request: status, slot_index, cleared_count.
//  - csr_* writes the timer reload value; always ready. Write it
//    only while no request is in flight.
//  - Each slot is a cell in a row; a request walks the row one cell per
//    cycle, and its result is registered once the walk reaches the
//    sequencer. One request is in flight at a time: the next one is
//    taken only after the last has left the cell row and been resolved.
//  - A new key is written into its slot by a broadcast at the end of the
//    walk, in the same cycle that the result is registered.
//  - The result register parts the sides: while rsp is stalled the next
//    request is still taken and swept; its result then waits until the
//    register frees up.
//  - Synchronous reset empties every slot, zeroes all timers and sets
//    the reload value to 4096; no clearing pass is needed.
`include "held_key_table_with_timers_defines.svh"

module held_key_table_with_timers import hkt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TIME_W-1:0] csr_data
);

   // wave[i] feeds cell i; wave[SLOTS] is the tail back to the sequencer
   wave_type          wave [SLOTS+1];
   commit_type        commit;
   logic [TIME_W-1:0] reload;
   logic [SLOTS-1:0]  wave_live;

   hkt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .reload    (reload),
      .wave_o    (wave[0]),
      .wave_i    (wave[SLOTS]),
      .commit_o  (commit)
   );

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      hkt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .reload     (reload),
         .wave_i     (wave[i]),
         .commit_i   (commit),
         .wave_o     (wave[i+1])
      );
      assign wave_live[i] = wave[i+1].valid;
   end

   // Checks
   `HKT_ASSERT_NEXT(a_cell0_takes_beat, req_valid && req_ready, wave[1].valid,
      "accepted request did not enter the first cell")
   `HKT_ASSERT_IMPL(a_one_sweep, 1'b1, $countones(wave_live) <= 1,
      "more than one sweep in the cell row")
   `HKT_ASSERT_IMPL(a_no_accept_at_tail, wave[SLOTS].valid, !req_ready,
      "request accepted while a sweep finishes")
   `HKT_ASSERT_NEXT(a_insert_reported, commit.valid,
      rsp_valid && (rsp_data.status == STATUS_INSERTED),
      "insert write without an inserted result")

endmodule

FILE: src/hkt_cell.sv
// One table slot: held code, countdown timer and one stage of the sweep.
module hkt_cell import hkt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  cell_index,
   input  logic [TIME_W-1:0] reload,
   input  wave_type          wave_i,
   input  commit_type        commit_i,
   output wave_type          wave_o
);

   logic [KEY_W-1:0]  code_ff, code_in;
   logic [TIME_W-1:0] timer_ff, timer_in;
   wave_type          wave_ff, wave_in;
   logic              hit;

   assign hit = (code_ff == wave_i.key) && (wave_i.key != '0);

   always_comb begin
      wave_in  = wave_i;
      code_in  = code_ff;
      timer_in = timer_ff;
      if (wave_i.valid) begin
         unique case (wave_i.op)
            OP_PRESS: begin
               // a nonzero key sits in at most one slot
               if (hit) begin
                  timer_in            = reload;
                  wave_in.match_found = 1'b1;
                  wave_in.match_idx   = cell_index;
               end else if ((code_ff == '0) && !wave_i.free_found) begin
                  wave_in.free_found = 1'b1;
                  wave_in.free_idx   = cell_index;
               end
            end
            OP_RELEASE: begin
               if (hit) begin
                  code_in       = '0;
                  wave_in.count = wave_i.count + CNT_W'(1);
               end
            end
            OP_TICK: begin
               timer_in = (timer_ff > wave_i.dt) ? (timer_ff - wave_i.dt) : '0;
            end
            default: ;
         endcase
      end
      if (commit_i.valid && (commit_i.idx == cell_index)) begin
         code_in  = commit_i.key;
         timer_in = reload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff       <= '0;
         timer_ff      <= '0;
         wave_ff.valid <= 1'b0;
      end else begin
         code_ff  <= code_in;
         timer_ff <= timer_in;
         wave_ff  <= wave_in;
      end
   end

   assign wave_o = wave_ff;

endmodule

FILE: src/hkt_ctrl.sv
// Sequencer: launches sweeps, resolves results, drives inserts and the register.
module hkt_ctrl import hkt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TIME_W-1:0] csr_data,
   output logic [TIME_W-1:0] reload,
   output wave_type          wave_o,
   input  wave_type          wave_i,
   output commit_type        commit_o
);

   ctrl_state_type    state_ff, state_in;
   wave_type          tail_ff;
   rsp_type           rsp_ff, result;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] reload_ff;
   logic              insert, load;

   assign csr_ready = 1'b1;
   assign reload    = reload_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // result of the finished sweep
   always_comb begin
      result.status        = STATUS_IGNORED;
      result.slot_index    = '0;
      result.cleared_count = '0;
      insert               = 1'b0;
      unique case (tail_ff.op)
         OP_PRESS: begin
            if (tail_ff.key == '0) begin
               result.status = STATUS_IGNORED;
            end else if (tail_ff.match_found) begin
               result.status     = STATUS_REFRESHED;
               result.slot_index = tail_ff.match_idx[3:0];
            end else if (tail_ff.free_found) begin
               result.status     = STATUS_INSERTED;
               result.slot_index = tail_ff.free_idx[3:0];
               insert            = 1'b1;
            end else begin
               result.status = STATUS_FULL;
            end
         end
         OP_RELEASE: begin
            result.status        = STATUS_RELEASED;
            result.cleared_count = (tail_ff.count > CNT_W'(CLEARED_MAX)) ?
                                   CLEARED_MAX : tail_ff.count[4:0];
         end
         OP_TICK: result.status = STATUS_TICKED;
         default: result.status = STATUS_IGNORED;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SWEEP;
         ST_SWEEP:  if (wave_i.valid) state_in = ST_FINISH;
         ST_FINISH: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready            = (state_ff == ST_IDLE);
      load                 = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in         = load || (rsp_valid_ff && !rsp_ready);
      wave_o               = '0;
      wave_o.valid         = req_valid && req_ready;
      wave_o.op            = req_data.operation;
      wave_o.key           = req_data.key_code;
      wave_o.dt            = req_data.elapsed_time;
      commit_o.valid       = load && insert;
      commit_o.idx         = tail_ff.free_idx;
      commit_o.key         = tail_ff.key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         reload_ff    <= RELOAD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) reload_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_SWEEP) && wave_i.valid) tail_ff <= wave_i;
      if (load) rsp_ff <= result;
   end

endmodule

FILE: verif/held_key_table_with_timers_tb.sv
// Testbench for the held key table: directed rows, random key events, scoreboard.
module held_key_table_with_timers_tb;
   import hkt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Operation code 3 has no name in the package; the table treats it as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int PHASE_ITEMS = 560;   // random beats per idling phase
   localparam int POOL_SIZE   = 22;    // a bit more keys than slots, so the table fills
   localparam int SETTLE      = 40;    // longer than a walk down the cell row
   localparam int STALL_LIMIT = 4000;  // cycles without any beat before giving up

   typedef struct {
      req_type ev;
      bit      typed;    // want is filled in by hand
      rsp_type want;
   } directed_row_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [TIME_W-1:0] csr_data = '0;

   // Shadow of the table state.
   logic [KEY_W-1:0]  held_keys [SLOTS];
   logic [TIME_W-1:0] key_timers [SLOTS];
   logic [TIME_W-1:0] reload_time;

   rsp_type          pending_results [$];
   directed_row_type directed_rows [$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   int req_gap_pct;
   int rsp_stall_pct;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   held_key_table_with_timers dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor: applies one key event to the shadow table, returns its result.
   // ---------------------------------------------------------------------------
   function automatic rsp_type apply_key_event(req_type ev);
      rsp_type res;
      int      hit_slot;
      int      free_slot;
      int      cleared;
      res       = '0;
      hit_slot  = -1;
      free_slot = -1;
      cleared   = 0;
      case (ev.operation)
         OP_PRESS: begin
            if (ev.key_code == '0) begin
               // key code zero marks an empty slot; a press of it does nothing
               res.status = STATUS_IGNORED;
            end else begin
               // highest matching slot wins; new keys go to the lowest free slot
               for (int i = 0; i < SLOTS; i++)
                  if (held_keys[i] == ev.key_code) hit_slot = i;
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (held_keys[i] == '0) free_slot = i;
               if (hit_slot >= 0) begin
                  key_timers[hit_slot] = reload_time;
                  res.status     = STATUS_REFRESHED;
                  res.slot_index = 4'(hit_slot);
               end else if (free_slot >= 0) begin
                  held_keys[free_slot]  = ev.key_code;
                  key_timers[free_slot] = reload_time;
                  res.status     = STATUS_INSERTED;
                  res.slot_index = 4'(free_slot);
               end else begin
                  res.status = STATUS_FULL;
               end
            end
         end
         OP_RELEASE: begin
            // release of key zero empties nothing
            if (ev.key_code != '0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (held_keys[i] == ev.key_code) begin
                     held_keys[i] = '0;
                     cleared++;
                  end
               end
            end
            res.status        = STATUS_RELEASED;
            res.cleared_count = (cleared > 31) ? CLEARED_MAX : 5'(cleared);
         end
         OP_TICK: begin
            // timers count down and stop at zero
            for (int i = 0; i < SLOTS; i++) begin
               if (key_timers[i] > ev.elapsed_time)
                  key_timers[i] = key_timers[i] - ev.elapsed_time;
               else
                  key_timers[i] = '0;
            end
            res.status = STATUS_TICKED;
         end
         default: begin
            res.status = STATUS_IGNORED;
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Directed table.
   // ---------------------------------------------------------------------------
   function automatic void add_row(logic [1:0] op, logic [KEY_W-1:0] key,
                                   logic [TIME_W-1:0] dt, bit typed,
                                   logic [2:0] st, logic [3:0] slot, logic [4:0] cnt);
      directed_row_type row;
      row.ev.operation     = op;
      row.ev.key_code      = key;
      row.ev.elapsed_time  = dt;
      row.typed            = typed;
      row.want.status        = st;
      row.want.slot_index    = slot;
      row.want.cleared_count = cnt;
      directed_rows.push_back(row);
   endfunction

   function automatic void load_directed_rows();
      // fresh table after reset
      add_row(OP_PRESS,   32'h0000_0000, 16'hFFFF, 1'b1, STATUS_IGNORED,   4'd0, 5'd0);
      add_row(OP_PRESS,   32'hFFFF_FFFF, 16'h0000, 1'b1, STATUS_INSERTED,  4'd0, 5'd0);
      add_row(OP_PRESS,   32'h0000_0001, 16'hFFFF, 1'b1, STATUS_INSERTED,  4'd1, 5'd0);
      add_row(OP_PRESS,   32'hFFFF_FFFF, 16'h0000, 1'b1, STATUS_REFRESHED, 4'd0, 5'd0);
      // widest tick drives every timer to zero, then a zero tick
      add_row(OP_TICK,    32'hA5A5_5A5A, 16'hFFFF, 1'b1, STATUS_TICKED,    4'd0, 5'd0);
      add_row(OP_TICK,    32'h0000_0000, 16'h0000, 1'b1, STATUS_TICKED,    4'd0, 5'd0);
      add_row(OP_RELEASE, 32'h0000_0000, 16'h1234, 1'b1, STATUS_RELEASED,  4'd0, 5'd0);
      add_row(OP_RELEASE, 32'hFFFF_FFFF, 16'h0000, 1'b1, STATUS_RELEASED,  4'd0, 5'd1);
      add_row(OP_UNUSED,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, STATUS_IGNORED,   4'd0, 5'd0);
      // fill every free slot, slot 0 first, then 2 up to the top
      for (int k = 0; k < SLOTS - 1; k++)
         add_row(OP_PRESS, 32'h8000_0000 | k, 16'(k), 1'b0, STATUS_INSERTED, 4'd0, 5'd0);
      add_row(OP_PRESS,   32'h7FFF_FFFF, 16'h0000, 1'b1, STATUS_FULL,      4'd0, 5'd0);
      add_row(OP_RELEASE, 32'h0000_0001, 16'h0000, 1'b1, STATUS_RELEASED,  4'd0, 5'd1);
   endfunction

   // ---------------------------------------------------------------------------
   // Random key events: mostly presses and releases over a small key pool so the
   // table refreshes, fills up and drops; the rest ticks, stray keys and noise.
   // ---------------------------------------------------------------------------
   function automatic void refill_key_pool();
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      key_pool[0] = 32'hFFFF_FFFF;
      key_pool[1] = 32'h0000_0001;
   endfunction

   function automatic req_type random_key_event();
      req_type ev;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 50)      ev.operation = OP_PRESS;
      else if (pick < 75) ev.operation = OP_RELEASE;
      else if (pick < 90) ev.operation = OP_TICK;
      else if (pick < 95) ev.operation = OP_UNUSED;
      else                ev.operation = 2'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 85)      ev.key_code = key_pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 90) ev.key_code = '0;
      else                ev.key_code = $urandom;
      pick = $urandom_range(99);
      if (pick < 10)      ev.elapsed_time = '0;
      else if (pick < 20) ev.elapsed_time = '1;
      else                ev.elapsed_time = 16'($urandom_range(16'hFFFF));
      return ev;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side. Valid goes up at an edge and stays until the beat is taken;
   // the expectation is queued at the accepting edge.
   // ---------------------------------------------------------------------------
   task automatic issue_event(req_type ev, bit typed, rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_key_event(ev);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Sender drops valid and holds off until every queued result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Reload write; only called with the table idle.
   task automatic write_reload(logic [TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      reload_time = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stall, compare each beat with the oldest expectation.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing outstanding: status %0d slot %0d cleared %0d",
                   rsp_data.status, rsp_data.slot_index, rsp_data.cleared_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.slot_index !== want.slot_index) begin
               $error("slot_index: expected %0d, actual %0d",
                      want.slot_index, rsp_data.slot_index);
               mismatch_count++;
            end
            if (rsp_data.cleared_count !== want.cleared_count) begin
               $error("cleared_count: expected %0d, actual %0d",
                      want.cleared_count, rsp_data.cleared_count);
               mismatch_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: any beat on any channel restarts the count.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: reset, directed rows, then three random phases with different
   // idling on each side, the reload register moved between them.
   // ---------------------------------------------------------------------------
   initial begin
      logic [TIME_W-1:0] phase_reload;
      for (int i = 0; i < SLOTS; i++) begin
         held_keys[i]  = '0;
         key_timers[i] = '0;
      end
      reload_time   = RELOAD_RESET;
      req_gap_pct   = 30;
      rsp_stall_pct = 87;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      load_directed_rows();
      foreach (directed_rows[i])
         issue_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_gap_pct   = 30;
               rsp_stall_pct = 87;
               phase_reload  = '0;
            end
            1: begin
               req_gap_pct   = 87;
               rsp_stall_pct = 30;
               phase_reload  = '1;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
               phase_reload  = 16'($urandom_range(16'hFFFF));
            end
         endcase
         write_reload(phase_reload);
         refill_key_pool();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // now and then the sender waits for the table to go idle,
            // and sometimes moves the reload while it is
            if ($urandom_range(49) == 0) begin
               drain_results();
               if ($urandom_range(1) == 0)
                  write_reload(16'($urandom_range(16'hFFFF)));
            end
            issue_event(random_key_event(), 1'b0, '0);
         end
         drain_results();
      end

      repeat (SETTLE) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/hkt_pkg.sv
src/hkt_cell.sv
src/hkt_ctrl.sv
src/held_key_table_with_timers.sv
verif/held_key_table_with_timers_tb.sv
